// ----- rtl/fsf_pkg.sv -----
// fsf_pkg: shared types and constants for the format string char formatter
// item and result word layouts, queue command codes, ascii constants
// no dependencies
`timescale 1ns / 1ps
package fsf_pkg;

	// character counter width
	localparam int COUNT_BITS = 16;

	// command queue depth
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// ascii codes
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	// result kinds
	localparam logic [1:0] KIND_CHAR  = 2'd0;
	localparam logic [1:0] KIND_COUNT = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// decimal digits of a 32-bit magnitude
	localparam int DEC_DIGITS = 10;
	localparam int DIG_AW     = $clog2(DEC_DIGITS);

	// reciprocal of ten, scaled by 2^35
	localparam logic [31:0] RECIP10   = 32'hCCCC_CCCD;
	localparam int          RECIP_SHF = 35;

	// commands from the front to the back
	typedef enum logic [2:0] {
		OP_CHAR    = 3'd0,
		OP_DEC     = 3'd1,
		OP_HEX     = 3'd2,
		OP_END_CNT = 3'd3,
		OP_END_ERR = 3'd4
	} fsf_op_t;

	typedef struct packed {
		fsf_op_t     op;
		logic [7:0]  ch;
		logic [31:0] arg;
	} fsf_cmd_t;

	// front to queue
	typedef struct packed {
		logic     push;
		fsf_cmd_t cmd;
	} fsf_push_t;

	// input word
	typedef struct packed {
		logic [7:0]  format_byte;
		logic [31:0] argument_word;
		logic        end_of_format;
	} fsf_in_t;

	// result word
	typedef struct packed {
		logic [7:0]  out_byte;
		logic [1:0]  out_kind;
		logic [15:0] printed_count;
		logic        last_of_run;
	} fsf_out_t;

	// uppercase hex digit
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = CH_ZERO + {4'd0, nib};
		end else begin
			r = CH_UA + {4'd0, nib} - 8'd10;
		end
		return r;
	endfunction

endpackage

// ----- rtl/fsf_front.sv -----
// fsf_front: accepts input words, tracks the conversion mode and classifies
// each byte into a command for the back end
// depends on fsf_pkg
`timescale 1ns / 1ps
module fsf_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  fsf_pkg::fsf_in_t item,
	input  logic             queue_full,
	output logic             item_stall,
	output fsf_pkg::fsf_push_t push
);
	import fsf_pkg::*;

	typedef enum logic [2:0] {
		M_NORMAL = 3'b001,
		M_PCT    = 3'b010,
		M_ERR    = 3'b100
	} mode_t;

	mode_t mode_q, mode_d;
	logic  accept;

	assign item_stall = queue_full;
	assign accept     = item_valid && !queue_full;

	// classify the byte against the current mode
	always_comb begin
		mode_d       = mode_q;
		push.push    = 1'b0;
		push.cmd.op  = OP_CHAR;
		push.cmd.ch  = item.format_byte;
		push.cmd.arg = item.argument_word;
		if (item.end_of_format) begin
			push.push = 1'b1;
			mode_d    = M_NORMAL;
			if (mode_q == M_NORMAL || mode_q == M_PCT) begin
				push.cmd.op = OP_END_CNT;
			end else begin
				push.cmd.op = OP_END_ERR;
			end
		end else begin
			case (mode_q)
				M_NORMAL: begin
					if (item.format_byte == CH_PCT) begin
						mode_d = M_PCT;
					end else begin
						push.push = 1'b1;
					end
				end
				M_PCT: begin
					mode_d = M_NORMAL;
					if (item.format_byte == CH_D) begin
						push.push   = 1'b1;
						push.cmd.op = OP_DEC;
					end else if (item.format_byte == CH_C) begin
						push.push   = 1'b1;
						push.cmd.ch = item.argument_word[7:0];
					end else if (item.format_byte == CH_X) begin
						push.push   = 1'b1;
						push.cmd.op = OP_HEX;
					end else if (item.format_byte == CH_PCT) begin
						push.push = 1'b1;
					end else begin
						mode_d = M_ERR;
					end
				end
				default: begin
					// error mode swallows everything up to the end word
				end
			endcase
		end
		if (!accept) begin
			push.push = 1'b0;
		end
	end

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_NORMAL;
		end else if (accept) begin
			mode_q <= mode_d;
		end
	end

endmodule

// ----- rtl/fsf_queue.sv -----
// fsf_queue: short command fifo between the front and the back end
// depends on fsf_pkg
`timescale 1ns / 1ps
module fsf_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  fsf_pkg::fsf_push_t push,
	input  logic               pop,
	output fsf_pkg::fsf_cmd_t  head,
	output logic               not_empty,
	output logic               full
);
	import fsf_pkg::*;

	fsf_cmd_t              mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wptr_q, rptr_q;
	logic [QUEUE_AW:0]     count_q;
	logic                  do_push, do_pop;

	assign full      = count_q == (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign head      = mem_q[rptr_q];
	assign do_push   = push.push && !full;
	assign do_pop    = pop && not_empty;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push.cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QUEUE_AW+1)'(QUEUE_DEPTH))
		else $error("queue fill count beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("back end popped an empty queue");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("push without pop did not grow the queue");

endmodule

// ----- rtl/fsf_back.sv -----
// fsf_back: carries out queued commands, converts numbers to ascii and
// keeps the character count; holds the registered result word
// depends on fsf_pkg
`timescale 1ns / 1ps
module fsf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  fsf_pkg::fsf_cmd_t head,
	input  logic              not_empty,
	output logic              pop,
	output logic              result_valid,
	input  logic              result_stall,
	output fsf_pkg::fsf_out_t result
);
	import fsf_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CONV  = 7'b0000010,
		S_SIGN  = 7'b0000100,
		S_DIGIT = 7'b0001000,
		S_HEX0  = 7'b0010000,
		S_HEXX  = 7'b0100000,
		S_NIB   = 7'b1000000
	} state_t;

	state_t                state_q, state_d;
	logic                  out_valid_q;
	fsf_out_t              out_q;
	logic                  out_free;
	logic                  load;
	fsf_out_t              ld;
	logic                  clr_cnt;
	logic [COUNT_BITS-1:0] cnt_q;

	logic [31:0]           mag_q;
	logic                  neg_q;
	logic [DIG_AW-1:0]     k_q, didx_q;
	logic [3:0]            dig_q [DEC_DIGITS];
	logic [63:0]           prod;
	logic [31:0]           quo, rem;

	logic [31:0]           hword_q;
	logic [2:0]            nidx_q, nstart;
	logic [3:0]            nib;

	assign out_free     = !out_valid_q || !result_stall;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// one decimal digit per cycle by reciprocal multiply
	assign prod = {32'd0, mag_q} * {32'd0, RECIP10};
	assign quo  = 32'(prod[63:RECIP_SHF]);
	assign rem  = mag_q - ((quo << 3) + (quo << 1));

	// leading nonzero nibble of the hex argument
	always_comb begin
		nstart = '0;
		for (int i = 0; i < 8; i++) begin
			if (head.arg[i*4 +: 4] != 4'd0) begin
				nstart = 3'(i);
			end
		end
	end

	assign nib = hword_q[{nidx_q, 2'b00} +: 4];

	// sequencer and result loading
	always_comb begin
		state_d          = state_q;
		pop              = 1'b0;
		load             = 1'b0;
		clr_cnt          = 1'b0;
		ld.out_byte      = '0;
		ld.out_kind      = KIND_CHAR;
		ld.printed_count = '0;
		ld.last_of_run   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (not_empty && out_free) begin
					pop = 1'b1;
					case (head.op)
						OP_CHAR: begin
							load           = 1'b1;
							ld.out_byte    = head.ch;
							ld.last_of_run = 1'b1;
						end
						OP_END_CNT: begin
							load             = 1'b1;
							clr_cnt          = 1'b1;
							ld.out_kind      = KIND_COUNT;
							ld.printed_count = 16'(cnt_q);
							ld.last_of_run   = 1'b1;
						end
						OP_END_ERR: begin
							load           = 1'b1;
							clr_cnt        = 1'b1;
							ld.out_kind    = KIND_ERROR;
							ld.last_of_run = 1'b1;
						end
						OP_DEC: state_d = S_CONV;
						OP_HEX: state_d = S_HEX0;
						default: begin
							// unknown command is dropped
						end
					endcase
				end
			end
			S_CONV: begin
				if (quo == 32'd0) begin
					state_d = neg_q ? S_SIGN : S_DIGIT;
				end
			end
			S_SIGN: begin
				if (out_free) begin
					load        = 1'b1;
					ld.out_byte = CH_MINUS;
					state_d     = S_DIGIT;
				end
			end
			S_DIGIT: begin
				if (out_free) begin
					load           = 1'b1;
					ld.out_byte    = CH_ZERO + {4'd0, dig_q[didx_q]};
					ld.last_of_run = didx_q == '0;
					if (didx_q == '0) begin
						state_d = S_IDLE;
					end
				end
			end
			S_HEX0: begin
				if (out_free) begin
					load        = 1'b1;
					ld.out_byte = CH_ZERO;
					state_d     = S_HEXX;
				end
			end
			S_HEXX: begin
				if (out_free) begin
					load        = 1'b1;
					ld.out_byte = CH_X;
					state_d     = S_NIB;
				end
			end
			S_NIB: begin
				if (out_free) begin
					load           = 1'b1;
					ld.out_byte    = hex_char(nib);
					ld.last_of_run = nidx_q == '0;
					if (nidx_q == '0) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control state, result valid and character count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			if (clr_cnt) begin
				cnt_q <= '0;
			end else if (load && ld.out_kind == KIND_CHAR && cnt_q != '1) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// conversion datapath
	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= ld;
		end
		if (state_q == S_IDLE && pop && head.op == OP_DEC) begin
			neg_q <= head.arg[31];
			mag_q <= head.arg[31] ? (~head.arg + 32'd1) : head.arg;
			k_q   <= '0;
		end else if (state_q == S_CONV) begin
			dig_q[k_q] <= rem[3:0];
			mag_q      <= quo;
			k_q        <= k_q + 1'b1;
			if (quo == 32'd0) begin
				didx_q <= k_q;
			end
		end else if (state_q == S_DIGIT && load) begin
			didx_q <= didx_q - 1'b1;
		end
		if (state_q == S_IDLE && pop && head.op == OP_HEX) begin
			hword_q <= head.arg;
			nidx_q  <= nstart;
		end else if (state_q == S_NIB && load) begin
			nidx_q <= nidx_q - 1'b1;
		end
	end

	a_conv_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CONV) |-> k_q < DIG_AW'(DEC_DIGITS))
		else $error("decimal conversion ran past ten digits");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		clr_cnt |=> cnt_q == '0)
		else $error("count not cleared after end word");

	a_digit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIGIT) |-> didx_q < DIG_AW'(DEC_DIGITS))
		else $error("digit index out of range");

endmodule

// ----- rtl/format_string_char_formatter.sv -----
// format_string_char_formatter: printf subset (%d %c %x %%) byte formatter
// item channel in: format byte, argument and end flag; result channel out:
// one ascii character, a final count or an error status per word
//
// usage: send one format byte per item word with its argument. plain bytes
// come back as one character; %d gives a minus sign if negative and up to ten
// digits, %x gives "0x" and up to eight uppercase digits, %c and %% one character. an item
// with end_of_format set answers the saturated character count (kind 1), or
// kind 2 if a bad specifier was seen, and starts a new format string.
// last_of_run marks the final result of each item.
// a result passes through the command queue and then the registered result
// word. %d and %x first take their command without a result; %d then works
// out its decimal digits by reciprocal multiply; after that every command
// gives one character per cycle unless result_stall holds the result.
// a four-entry command queue lets the front keep accepting while the back
// end works; item_stall rises only when that queue is full.
// reset clears mode, count, queue and result valid. while result_stall is
// high a valid result word holds and the back end waits to load the next.
// depends on fsf_pkg, fsf_front, fsf_queue, fsf_back
`timescale 1ns / 1ps
module format_string_char_formatter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  fsf_pkg::fsf_in_t  item,
	output logic              result_valid,
	input  logic              result_stall,
	output fsf_pkg::fsf_out_t result
);
	import fsf_pkg::*;

	fsf_push_t push;
	fsf_cmd_t  head;
	logic      not_empty, full, pop;

	// byte classification
	fsf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.queue_full (full),
		.item_stall (item_stall),
		.push       (push)
	);

	// command queue
	fsf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.full      (full)
	);

	// conversion and output
	fsf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.not_empty    (not_empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
